// ===== hw/rtl/utf8ws_pkg.sv =====
// utf8ws_pkg: shared types, constants and byte classification functions
// for the utf-8 word statistics counter
// no dependencies
package utf8ws_pkg;

  localparam int unsigned ResultWidth = 32;

  // utf-8 lead byte patterns
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;

  // folded base letters
  localparam logic [7:0] BaseA = 8'h61;
  localparam logic [7:0] BaseE = 8'h65;
  localparam logic [7:0] BaseI = 8'h69;
  localparam logic [7:0] BaseO = 8'h6F;
  localparam logic [7:0] BaseU = 8'h75;
  localparam logic [7:0] BaseC = 8'h63;

  typedef struct packed {
    logic vowel;
    logic consonant;
    logic word_char;
    logic mark;
    logic separator;
  } char_class_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_vowel_letter(input logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return is_letter(c) && (l inside {BaseA, BaseE, BaseI, BaseO, BaseU});
  endfunction

  function automatic logic is_mark(input logic [7:0] c);
    return (c inside {8'h27, 8'h98, 8'h99});
  endfunction

  function automatic logic is_delimiter(input logic [7:0] c);
    return (c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h2D, 8'h22, 8'h9D, 8'h5B,
                      8'h5D, 8'h28, 8'h29, 8'h2E, 8'h2C, 8'h3A, 8'h3B, 8'h3F,
                      8'h21, 8'h93, 8'hA6, 8'hAB, 8'hBB});
  endfunction

  function automatic logic is_digit_underscore(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], 8'h5F});
  endfunction

  // accented portuguese letters (second byte of a 2-byte sequence)
  function automatic logic [7:0] fold_accent(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'hA0:8'hA3], [8'h80:8'h83]}) r = BaseA;
    else if (c inside {[8'hA8:8'hAA], [8'h88:8'h8A]}) r = BaseE;
    else if (c inside {[8'hAC:8'hAD], [8'h8C:8'h8D]}) r = BaseI;
    else if (c inside {[8'hB2:8'hB5], [8'h92:8'h95]}) r = BaseO;
    else if (c inside {[8'hB9:8'hBA], [8'h99:8'h9A]}) r = BaseU;
    else if (c inside {8'hA7, 8'h87}) r = BaseC;
    return r;
  endfunction

endpackage

// ===== hw/rtl/utf8ws_classify.sv =====
// utf8ws_classify: folds an accented final byte and sorts it into classes
// depends on utf8ws_pkg
module utf8ws_classify (
  input  logic [7:0]               char_byte,
  input  logic                     fold_en,
  output utf8ws_pkg::char_class_t  cls
);
  import utf8ws_pkg::*;

  logic [7:0] c;
  logic       v;
  logic       k;

  assign c = fold_en ? fold_accent(char_byte) : char_byte;
  assign v = is_vowel_letter(c);
  assign k = is_letter(c) && !v;

  assign cls.vowel     = v;
  assign cls.consonant = k;
  assign cls.word_char = v || k || is_digit_underscore(c);
  assign cls.mark      = is_mark(c);
  assign cls.separator = is_delimiter(c);

endmodule

// ===== hw/rtl/utf8ws_sat_counter.sv =====
// utf8ws_sat_counter: saturating event counter with synchronous clear
// no package dependencies
module utf8ws_sat_counter #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   inc,
  input  logic                   clr,
  output logic [COUNT_WIDTH-1:0] value_inc
);
  logic [COUNT_WIDTH-1:0] count;

  // value including this cycle's event, held at all ones
  assign value_inc = (inc && !(&count)) ? count + COUNT_WIDTH'(1) : count;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      count <= '0;
    end else begin
      count <= value_inc;
    end
  end

endmodule

// ===== hw/rtl/utf8_word_stats_counter.sv =====
// channel | dir | handshake                       | payload
// s_axis  | in  | s_axis_tvalid / s_axis_tready   | tdata[7:0] data_byte, tlast end_of_text
// m_axis  | out | m_axis_tvalid / m_axis_tready   | tdata[95:0] three totals
//
// one byte per cycle sustained while the input is not stalled: a byte goes into the input
// register, is classified and applied to the word state when it leaves that register
// a result is registered in the output register when its end_of_text byte leaves the input register
// rst is synchronous, active high, and clears the valid flags, the word state and the counters
// a held result only stalls the input when an end_of_text byte is waiting
// depends on utf8ws_pkg, utf8ws_classify, utf8ws_sat_counter
module utf8_word_stats_counter #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // [31:0] word_total, [63:32] vowel_start_total,
                                      // [95:64] consonant_end_total
);
  import utf8ws_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // word and sequence state
  logic [1:0] continuation_left, continuation_left_next;
  logic       two_byte_sequence, two_byte_sequence_next;
  logic       inside_word, inside_word_next;
  logic       last_was_consonant, last_was_consonant_next;

  logic        classify_en;
  logic        fold_en;
  char_class_t cls;

  logic inc_word, inc_vowel, inc_cons;
  logic advance;
  logic out_free;

  logic [COUNT_WIDTH-1:0] word_cnt, vowel_cnt, cons_cnt;
  logic [ResultWidth-1:0] word_res, vowel_res, cons_res;

  // output register
  logic                   out_valid;
  logic [ResultWidth-1:0] out_word, out_vowel, out_cons;

  // a result slot is only needed for an end_of_text byte
  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // sequence tracking: only the final byte of a sequence is classified
  always_comb begin
    continuation_left_next = continuation_left;
    two_byte_sequence_next = two_byte_sequence;
    classify_en            = 1'b0;
    fold_en                = 1'b0;
    if (continuation_left != 2'd0) begin
      continuation_left_next = continuation_left - 2'd1;
      if (continuation_left == 2'd1) begin
        classify_en            = 1'b1;
        fold_en                = two_byte_sequence;
        two_byte_sequence_next = 1'b0;
      end
    end else if ((in_byte & Lead4Mask) == Lead4Code) begin
      continuation_left_next = 2'd3;
      two_byte_sequence_next = 1'b0;
    end else if ((in_byte & Lead3Mask) == Lead3Code) begin
      continuation_left_next = 2'd2;
      two_byte_sequence_next = 1'b0;
    end else if ((in_byte & Lead2Mask) == Lead2Code) begin
      continuation_left_next = 2'd1;
      two_byte_sequence_next = 1'b1;
    end else begin
      classify_en = 1'b1;
    end
  end

  utf8ws_classify u_classify (
    .char_byte (in_byte),
    .fold_en   (fold_en),
    .cls       (cls)
  );

  // word state machine
  always_comb begin
    inside_word_next        = inside_word;
    last_was_consonant_next = last_was_consonant;
    inc_word                = 1'b0;
    inc_vowel               = 1'b0;
    inc_cons                = 1'b0;
    if (classify_en) begin
      if (inside_word) begin
        inc_cons                = cls.separator && last_was_consonant;
        inside_word_next        = cls.word_char || cls.mark;
        last_was_consonant_next = cls.consonant;
      end else begin
        if (cls.word_char) begin
          inc_vowel        = cls.vowel;
          inc_word         = 1'b1;
          inside_word_next = 1'b1;
          if (cls.consonant) begin
            last_was_consonant_next = 1'b1;
          end
        end
        if (cls.separator || cls.mark) begin
          inc_cons                = last_was_consonant;
          last_was_consonant_next = 1'b0;
          inside_word_next        = 1'b0;
        end
      end
    end
    // an open word ending in a consonant closes at end of text; a
    // classify increment always clears the flag, so at most one event
    if (in_last && last_was_consonant_next) begin
      inc_cons = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      continuation_left  <= 2'd0;
      two_byte_sequence  <= 1'b0;
      inside_word        <= 1'b0;
      last_was_consonant <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        continuation_left  <= 2'd0;
        two_byte_sequence  <= 1'b0;
        inside_word        <= 1'b0;
        last_was_consonant <= 1'b0;
      end else begin
        continuation_left  <= continuation_left_next;
        two_byte_sequence  <= two_byte_sequence_next;
        inside_word        <= inside_word_next;
        last_was_consonant <= last_was_consonant_next;
      end
    end
  end

  utf8ws_sat_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_word_cnt (
    .clk       (clk),
    .rst       (rst),
    .inc       (advance && inc_word),
    .clr       (advance && in_last),
    .value_inc (word_cnt)
  );

  utf8ws_sat_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_vowel_cnt (
    .clk       (clk),
    .rst       (rst),
    .inc       (advance && inc_vowel),
    .clr       (advance && in_last),
    .value_inc (vowel_cnt)
  );

  utf8ws_sat_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_cons_cnt (
    .clk       (clk),
    .rst       (rst),
    .inc       (advance && inc_cons),
    .clr       (advance && in_last),
    .value_inc (cons_cnt)
  );

  // totals are reported on 32 bits, clamped when the counters are wider
  generate
    if (COUNT_WIDTH > ResultWidth) begin : g_clamp
      assign word_res  = (|word_cnt[COUNT_WIDTH-1:ResultWidth]) ? '1
                                                                 : word_cnt[ResultWidth-1:0];
      assign vowel_res = (|vowel_cnt[COUNT_WIDTH-1:ResultWidth]) ? '1
                                                                  : vowel_cnt[ResultWidth-1:0];
      assign cons_res  = (|cons_cnt[COUNT_WIDTH-1:ResultWidth]) ? '1
                                                                 : cons_cnt[ResultWidth-1:0];
    end else begin : g_extend
      assign word_res  = ResultWidth'(word_cnt);
      assign vowel_res = ResultWidth'(vowel_cnt);
      assign cons_res  = ResultWidth'(cons_cnt);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_word  <= word_res;
      out_vowel <= vowel_res;
      out_cons  <= cons_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_cons, out_vowel, out_word};

endmodule

// ===== hw/rtl/utf8ws_checker.sv =====
// utf8ws_checker: port-level checks on the word statistics counter,
// bound to utf8_word_stats_counter; no package dependencies
module utf8ws_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  // no result survives a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // vowel-initial words are a subset of all words
  a_vowel_le_words: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[63:32] <= m_axis_tdata[31:0]))
    else $error("vowel_start_total exceeds word_total");

  // each word closes with at most one consonant ending
  a_cons_le_words: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[95:64] <= m_axis_tdata[31:0]))
    else $error("consonant_end_total exceeds word_total");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with no result held");

endmodule

bind utf8_word_stats_counter utf8ws_checker u_utf8ws_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// testbench for utf8_word_stats_counter: streams utf-8 texts in, checks the three
// totals given at each end_of_text against typed totals or a predictor of the word
// counting; depends only on the rtl of utf8_word_stats_counter
module testbench;

  localparam int TOTAL_W     = 32;
  localparam int TEXT_BYTES  = 1250;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;
  localparam int DIR_ROWS    = 23;

  // utf-8 lead byte patterns
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;

  // leads used to build sequences
  localparam logic [7:0] LEAD_LATIN1 = 8'hC2;
  localparam logic [7:0] LEAD_LATIN  = 8'hC3;
  localparam logic [7:0] LEAD_PUNCT  = 8'hE2;
  localparam logic [7:0] LEAD_EMOJI  = 8'hF0;
  localparam logic [7:0] APOSTROPHE  = 8'h27;
  localparam logic [7:0] UNDERSCORE  = 8'h5F;

  localparam logic [7:0] ASCII_SEPS [16] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h2D, 8'h22,
                                             8'h5B, 8'h5D, 8'h28, 8'h29, 8'h2E, 8'h2C,
                                             8'h3A, 8'h3B, 8'h3F, 8'h21};
  // final bytes of e2 80 xx punctuation: quotes, dash, ellipsis
  localparam logic [7:0] PUNCT_TAILS [6] = '{8'h9C, 8'h9D, 8'h93, 8'h98, 8'h99, 8'hA6};

  typedef struct packed {
    logic [TOTAL_W-1:0] consonant_end;
    logic [TOTAL_W-1:0] vowel_start;
    logic [TOTAL_W-1:0] words;
  } stats_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    stats_t     totals;
  } dir_row_t;

  localparam stats_t NO_TOTALS = '0;

  // short texts with obvious totals first, then one mixed text left to the predictor
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{8'h61, 1'b1, 1'b1, '{32'd0, 32'd1, 32'd1}},  // "a": one word starting with a vowel
    '{8'h5A, 1'b1, 1'b1, '{32'd1, 32'd0, 32'd1}},  // "Z": open consonant word at end
    '{8'hFF, 1'b1, 1'b1, NO_TOTALS},               // invalid byte only
    '{LEAD_LATIN, 1'b1, 1'b1, NO_TOTALS},          // 2-byte sequence cut at its lead
    '{LEAD_EMOJI, 1'b0, 1'b0, NO_TOTALS},
    '{8'h9F, 1'b0, 1'b0, NO_TOTALS},
    '{8'h98, 1'b1, 1'b1, NO_TOTALS},               // 4-byte sequence cut in the middle
    '{8'h45, 1'b0, 1'b0, NO_TOTALS},               // E
    '{8'h74, 1'b0, 1'b0, NO_TOTALS},               // t
    '{APOSTROPHE, 1'b0, 1'b0, NO_TOTALS},
    '{8'h73, 1'b0, 1'b0, NO_TOTALS},               // s
    '{8'h20, 1'b0, 1'b0, NO_TOTALS},
    '{LEAD_LATIN, 1'b0, 1'b0, NO_TOTALS},
    '{8'hA7, 1'b0, 1'b0, NO_TOTALS},               // c cedilla folds to c
    '{8'h61, 1'b0, 1'b0, NO_TOTALS},
    '{LEAD_PUNCT, 1'b0, 1'b0, NO_TOTALS},
    '{8'h80, 1'b0, 1'b0, NO_TOTALS},
    '{8'h9D, 1'b0, 1'b0, NO_TOTALS},               // closing quote, not folded
    '{UNDERSCORE, 1'b0, 1'b0, NO_TOTALS},
    '{8'h39, 1'b0, 1'b0, NO_TOTALS},
    '{8'h80, 1'b0, 1'b0, NO_TOTALS},               // stray continuation ends the word
    '{8'h78, 1'b0, 1'b0, NO_TOTALS},               // x
    '{8'h00, 1'b1, 1'b0, NO_TOTALS}                // nul ends the word, no consonant ending
  };

  logic          clk;
  logic          rst           = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [7:0]    s_axis_tdata  = 8'h00;  // [7:0] data_byte
  logic          s_axis_tlast  = 1'b0;   // end_of_text
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [95:0]   m_axis_tdata;           // [31:0] word_total, [63:32] vowel_start_total,
                                         // [95:64] consonant_end_total

  // predictor state
  logic [1:0]         seq_left;
  logic               seq_two_byte;
  logic               in_word;
  logic               prev_consonant;
  logic [TOTAL_W-1:0] n_words;
  logic [TOTAL_W-1:0] n_vowel_start;
  logic [TOTAL_W-1:0] n_consonant_end;

  stats_t     expected_totals [$];
  logic [7:0] text_bytes [$];
  int         bytes_sent    = 0;
  int         error_count   = 0;
  int         cycle_count   = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         phase         = 0;

  utf8_word_stats_counter #(
    .COUNT_WIDTH(TOTAL_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL utf8_word_stats_counter");
      $finish;
    end
  end

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= REPORT_MAX) $display("error: %s", msg);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic logic is_letter_ch(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic vowel_letter(input logic [7:0] c);
    logic [7:0] low;
    low = c | 8'h20;
    return is_letter_ch(c) && (low == 8'h61 || low == 8'h65 || low == 8'h69 ||
                               low == 8'h6F || low == 8'h75);
  endfunction

  function automatic logic separator_char(input logic [7:0] c);
    case (c)
      8'h20, 8'h09, 8'h0A, 8'h0D, 8'h2D, 8'h22, 8'h9D, 8'h5B, 8'h5D, 8'h28, 8'h29,
      8'h2E, 8'h2C, 8'h3A, 8'h3B, 8'h3F, 8'h21, 8'h93, 8'hA6, 8'hAB, 8'hBB: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // accented portuguese letters back to their base letter
  function automatic logic [7:0] unaccent(input logic [7:0] c);
    if ((c >= 8'hA0 && c <= 8'hA3) || (c >= 8'h80 && c <= 8'h83)) return 8'h61;
    if ((c >= 8'hA8 && c <= 8'hAA) || (c >= 8'h88 && c <= 8'h8A)) return 8'h65;
    if ((c >= 8'hAC && c <= 8'hAD) || (c >= 8'h8C && c <= 8'h8D)) return 8'h69;
    if ((c >= 8'hB2 && c <= 8'hB5) || (c >= 8'h92 && c <= 8'h95)) return 8'h6F;
    if ((c >= 8'hB9 && c <= 8'hBA) || (c >= 8'h99 && c <= 8'h9A)) return 8'h75;
    if (c == 8'hA7 || c == 8'h87) return 8'h63;
    return c;
  endfunction

  function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] n);
    return (n == '1) ? n : n + 1'b1;
  endfunction

  function automatic void step_word_fsm(input logic [7:0] c);
    logic vowel_hit, cons_hit, word_hit, mark_hit, sep_hit;
    vowel_hit = vowel_letter(c);
    cons_hit  = is_letter_ch(c) && !vowel_hit;
    word_hit  = vowel_hit || cons_hit || (c >= 8'h30 && c <= 8'h39) || c == UNDERSCORE;
    mark_hit  = (c == APOSTROPHE || c == 8'h98 || c == 8'h99);
    sep_hit   = separator_char(c);
    if (in_word) begin
      if (sep_hit && prev_consonant) n_consonant_end = bump(n_consonant_end);
      in_word        = word_hit || mark_hit;
      prev_consonant = cons_hit;
    end else begin
      if (word_hit) begin
        if (vowel_hit) n_vowel_start = bump(n_vowel_start);
        if (cons_hit) prev_consonant = 1'b1;
        in_word = 1'b1;
        n_words = bump(n_words);
      end
      if (sep_hit || mark_hit) begin
        if (prev_consonant) n_consonant_end = bump(n_consonant_end);
        prev_consonant = 1'b0;
        in_word        = 1'b0;
      end
    end
  endfunction

  function automatic void clear_counts();
    seq_left        = 2'd0;
    seq_two_byte    = 1'b0;
    in_word         = 1'b0;
    prev_consonant  = 1'b0;
    n_words         = '0;
    n_vowel_start   = '0;
    n_consonant_end = '0;
  endfunction

  // one accepted byte; gives the totals when it ends the text
  function automatic logic take_text_byte(input logic [7:0] b, input logic eot,
                                          output stats_t totals);
    totals = NO_TOTALS;
    if (seq_left != 2'd0) begin
      seq_left = seq_left - 2'd1;
      if (seq_left == 2'd0) begin
        step_word_fsm(seq_two_byte ? unaccent(b) : b);
        seq_two_byte = 1'b0;
      end
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      seq_left     = 2'd3;
      seq_two_byte = 1'b0;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      seq_left     = 2'd2;
      seq_two_byte = 1'b0;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      seq_left     = 2'd1;
      seq_two_byte = 1'b1;
    end else begin
      step_word_fsm(b);
    end
    if (!eot) return 1'b0;
    // an open word ending in a consonant closes at end of text
    if (prev_consonant) n_consonant_end = bump(n_consonant_end);
    totals.words         = n_words;
    totals.vowel_start   = n_vowel_start;
    totals.consonant_end = n_consonant_end;
    clear_counts();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // holds the byte until its transaction completes, then predicts
  task automatic offer_byte(input logic [7:0] b, input logic eot, input logic typed,
                            input stats_t typed_totals);
    stats_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    do @(posedge clk); while (!s_axis_tready);
    if (take_text_byte(b, eot, predicted))
      expected_totals.push_back(typed ? typed_totals : predicted);
    bytes_sent++;
  endtask

  function automatic void add_word();
    int len;
    int pick;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 70)
        text_bytes.push_back(($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25)));
      else if (pick < 80)
        text_bytes.push_back(8'h30 + 8'($urandom_range(9)));
      else if (pick < 85)
        text_bytes.push_back(UNDERSCORE);
      else if (pick < 95) begin
        // any continuation byte, half of which are accented letters
        text_bytes.push_back(LEAD_LATIN);
        text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else
        text_bytes.push_back(APOSTROPHE);
    end
  endfunction

  // mostly well formed text with words, punctuation and multibyte sequences,
  // a little noise, and now and then a sequence cut short at the end
  function automatic void compose_text();
    int target;
    text_bytes.delete();
    target = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
    while (text_bytes.size() < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3: add_word();
        4, 5: text_bytes.push_back(ASCII_SEPS[4'($urandom_range(15))]);
        6: begin
          text_bytes.push_back(LEAD_PUNCT);
          text_bytes.push_back(8'h80);
          text_bytes.push_back(PUNCT_TAILS[3'($urandom_range(5))]);
        end
        7: begin
          // guillemets
          text_bytes.push_back(LEAD_LATIN1);
          text_bytes.push_back($urandom_range(1) ? 8'hAB : 8'hBB);
        end
        8: begin
          text_bytes.push_back(LEAD_EMOJI);
          repeat (3) text_bytes.push_back(8'($urandom_range(255)));
        end
        default: text_bytes.push_back(8'($urandom_range(255)));
      endcase
    end
    if (text_bytes.size() > 1 && $urandom_range(5) == 0) void'(text_bytes.pop_back());
  endfunction

  initial begin : stimulus
    dir_row_t row;
    clear_counts();
    while (rst) @(posedge clk);

    send_idle_pct = 30;
    recv_idle_pct <= 64;
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED_ROWS[5'(r)];
      offer_byte(row.data, row.last, row.typed, row.totals);
    end

    // phase 0: sender idles less, phase 1: receiver idles less, phase 2: no idling
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 30 : (p == 1) ? 64 : 0;
      recv_idle_pct <= (p == 0) ? 64 : (p == 1) ? 30 : 0;
      phase <= p;
      while (bytes_sent < DIR_ROWS + (p + 1) * TEXT_BYTES / 3) begin
        compose_text();
        for (int j = 0; j < text_bytes.size(); j++)
          offer_byte(text_bytes[j], j == text_bytes.size() - 1, 1'b0, NO_TOTALS);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (expected_totals.size() != 0) @(posedge clk);
    // room for a stray extra result to show up
    repeat (16) @(posedge clk);
    if (error_count == 0)
      $display("PASS utf8_word_stats_counter");
    else
      $display("FAIL utf8_word_stats_counter");
    $finish;
  end

  // ---------------------------------------------------------------- result side

  // random backpressure; once, at the start of the no-idle phase, a long
  // hold-off so the block fills up and stalls its input
  initial begin : receiver
    int  hold_left;
    logic held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 2 && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_totals
    stats_t want;
    stats_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_totals.size() == 0) begin
        flag_error($sformatf("result with nothing expected: %0d %0d %0d",
                             got.words, got.vowel_start, got.consonant_end));
      end else begin
        want = expected_totals.pop_front();
        if (got.words !== want.words)
          flag_error($sformatf("word_total expected %0d got %0d", want.words, got.words));
        if (got.vowel_start !== want.vowel_start)
          flag_error($sformatf("vowel_start_total expected %0d got %0d",
                               want.vowel_start, got.vowel_start));
        if (got.consonant_end !== want.consonant_end)
          flag_error($sformatf("consonant_end_total expected %0d got %0d",
                               want.consonant_end, got.consonant_end));
      end
    end
  end

endmodule
